/* design/sacl_pkg.sv */
// ---------------------------------------------------------------------------
// sacl_pkg
// shared constants for the set-associative tag cache with lru replacement
// ---------------------------------------------------------------------------
package sacl_pkg;

   localparam int ADDR_W     = 32;
   localparam int OFF_W      = 4;
   localparam int IDX_W      = 3;
   localparam int WAY_OUT_W  = 2;
   localparam int SET_OUT_W  = 6;
   localparam int CNT_W      = 32;
   localparam int RSP_W      = 80;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int SHAMT_W    = 5;

   // per-way entry layout inside a memory row: tag, valid, age
   localparam int TAG_LSB    = 0;
   localparam int VLD_BIT    = ADDR_W;
   localparam int AGE_LSB    = ADDR_W + 1;

   // register select bit of the byte address and its codes
   localparam int   CSR_SEL_BIT = 2;
   localparam logic REG_OFFSET  = 1'b0;
   localparam logic REG_INDEX   = 1'b1;

   localparam logic [OFF_W-1:0] OFFSET_RST = 4'd4;
   localparam logic [IDX_W-1:0] INDEX_RST  = 3'd6;

endpackage

/* design/sacl_tag_ram.sv */
// ---------------------------------------------------------------------------
// sacl_tag_ram
// one-row-per-set memory, one write port, one read port, registered read
// ---------------------------------------------------------------------------
module sacl_tag_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 144
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sacl_way_logic.sv */
// ---------------------------------------------------------------------------
// sacl_way_logic
// tag compare, victim choice and lru age update for one set row
// ---------------------------------------------------------------------------
module sacl_way_logic #(
   parameter int WAYS  = 4,
   parameter int WAY_W = 2,
   parameter int AGE_W = 2
) (
   input  logic [WAYS*(sacl_pkg::ADDR_W+1+AGE_W)-1:0] row,
   input  logic [sacl_pkg::ADDR_W-1:0]                tag,
   output logic                                       hit,
   output logic [WAY_W-1:0]                           way,
   output logic [WAYS*(sacl_pkg::ADDR_W+1+AGE_W)-1:0] new_row
);
   import sacl_pkg::*;

   localparam int ENT_W = ADDR_W + 1 + AGE_W;

   logic [WAYS-1:0][ADDR_W-1:0] tags;
   logic [WAYS-1:0]             valids;
   logic [WAYS-1:0][AGE_W-1:0]  ages;
   logic [WAYS-1:0]             hit_vec;
   logic [WAYS-1:0]             inv_vec;
   logic [WAYS-1:0]             old_vec;
   logic [WAYS-1:0]             pick;
   logic [WAY_W-1:0]            way_c;
   logic [AGE_W-1:0]            touched_age;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         tags[w]    = row[w*ENT_W + TAG_LSB +: ADDR_W];
         valids[w]  = row[w*ENT_W + VLD_BIT];
         ages[w]    = row[w*ENT_W + AGE_LSB +: AGE_W];
         hit_vec[w] = valids[w] && (tags[w] == tag);
         inv_vec[w] = !valids[w];
         // ages form a permutation, so the oldest way carries the top age
         old_vec[w] = (ages[w] == AGE_W'(WAYS - 1));
      end
   end

   always_comb begin
      if (|hit_vec) begin
         pick = hit_vec;
      end else if (|inv_vec) begin
         pick = inv_vec;
      end else begin
         pick = old_vec;
      end
      way_c = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (pick[w]) begin
            way_c = WAY_W'(w);
         end
      end
   end

   assign touched_age = ages[way_c];

   always_comb begin
      new_row = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (way_c == WAY_W'(w)) begin
            new_row[w*ENT_W + TAG_LSB +: ADDR_W] = tag;
            new_row[w*ENT_W + VLD_BIT]           = 1'b1;
            new_row[w*ENT_W + AGE_LSB +: AGE_W]  = '0;
         end else begin
            new_row[w*ENT_W + TAG_LSB +: ADDR_W] = tags[w];
            new_row[w*ENT_W + VLD_BIT]           = valids[w];
            if (ages[w] < touched_age) begin
               new_row[w*ENT_W + AGE_LSB +: AGE_W] = ages[w] + AGE_W'(1);
            end else begin
               new_row[w*ENT_W + AGE_LSB +: AGE_W] = ages[w];
            end
         end
      end
   end

   assign hit = |hit_vec;
   assign way = way_c;

endmodule

/* design/set_assoc_cache_lru_unit.sv */
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_unit
// tag-only set-associative cache with true lru replacement and access/miss counts
// ---------------------------------------------------------------------------
//  channel  | ports   | contents
//  request  | req_*   | tdata[31:0] address
//  response | rsp_*   | tdata hit, way_used, set_index, access_total, miss_total
//  config   | csr_*   | 0x0 offset_bits, 0x4 index_bits
//
//  an item passes the registered row read of the set memory, then compare,
//  lru update and write back of that row; no new item is taken until then.
//  after reset a clearing pass writes every set row, and no item
//  is taken meanwhile; config writes are taken at any time.
//  a full response register holds the lookup until the response is taken.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_unit #(
   parameter int WAYS = 4,
   parameter int SETS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sacl_pkg::ADDR_W-1:0]   req_tdata,   // [31:0] address
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] hit, [2:1] way_used, [8:3] set_index, [40:9] access_total,
   // [72:41] miss_total, [79:73] zero
   output logic [sacl_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sacl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sacl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sacl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import sacl_pkg::*;

   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W   = WAY_W;
   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int SET_LIM = $clog2(SETS + 1) - 1;
   localparam int ENT_W   = ADDR_W + 1 + AGE_W;
   localparam int ROW_W   = WAYS * ENT_W;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [SET_W-1:0]    clr_ff, clr_in;
   logic [OFF_W-1:0]    offset_ff;
   logic [IDX_W-1:0]    index_ff;
   logic [SET_W-1:0]    set_ff;
   logic [ADDR_W-1:0]   tag_ff;
   logic [CNT_W-1:0]    access_ff, access_in;
   logic [CNT_W-1:0]    miss_ff, miss_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;
   logic [SET_OUT_W-1:0] rsp_set_ff;

   logic                accept;
   logic                csr_wr;
   logic [IDX_W-1:0]    ib_c;
   logic [SHAMT_W-1:0]  shamt_c;
   logic [ADDR_W-1:0]   set_full_c;
   logic [SET_W-1:0]    set_c;
   logic [ADDR_W-1:0]   tag_c;
   logic                load_out;
   logic                wr_en;
   logic [SET_W-1:0]    wr_addr;
   logic [ROW_W-1:0]    wr_data;
   logic [ROW_W-1:0]    rd_row;
   logic [ROW_W-1:0]    upd_row;
   logic [ROW_W-1:0]    clear_row;
   logic                lk_hit;
   logic [WAY_W-1:0]    lk_way;

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RST;
         index_ff  <= INDEX_RST;
      end else if (csr_wr) begin
         case (csr_paddr[CSR_SEL_BIT])
            REG_OFFSET: offset_ff <= csr_pwdata[OFF_W-1:0];
            REG_INDEX:  index_ff  <= csr_pwdata[IDX_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_SEL_BIT])
         REG_OFFSET: csr_prdata = CSR_DW'(offset_ff);
         REG_INDEX:  csr_prdata = CSR_DW'(index_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // address split
   always_comb begin
      if (int'(index_ff) > SET_LIM) begin
         ib_c = IDX_W'(SET_LIM);
      end else begin
         ib_c = index_ff;
      end
      shamt_c    = SHAMT_W'(offset_ff) + SHAMT_W'(ib_c);
      set_full_c = (req_tdata >> offset_ff) & ((ADDR_W'(1) << ib_c) - ADDR_W'(1));
      set_c      = SET_W'(set_full_c);
      tag_c      = req_tdata >> shamt_c;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      clear_row = '0;
      for (int w = 0; w < WAYS; w++) begin
         clear_row[w*ENT_W + AGE_LSB +: AGE_W] = AGE_W'(w);
      end
   end

   assign wr_en   = (state_ff == ST_CLEAR) || load_out;
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? clear_row : upd_row;

   sacl_tag_ram #(
      .DEPTH (SETS),
      .AW    (SET_W),
      .DW    (ROW_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (set_c),
      .rd_data (rd_row)
   );

   sacl_way_logic #(
      .WAYS  (WAYS),
      .WAY_W (WAY_W),
      .AGE_W (AGE_W)
   ) u_way (
      .row     (rd_row),
      .tag     (tag_ff),
      .hit     (lk_hit),
      .way     (lk_way),
      .new_row (upd_row)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      access_in    = access_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (load_out) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               access_in    = access_ff + CNT_W'(1);
               if (!lk_hit) begin
                  miss_in = miss_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         access_ff    <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         access_ff    <= access_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= set_c;
         tag_ff <= tag_c;
      end
      if (load_out) begin
         rsp_hit_ff <= lk_hit;
         rsp_way_ff <= WAY_OUT_W'(lk_way);
         rsp_set_ff <= SET_OUT_W'(set_ff);
      end
   end

   // counters hold the totals of the item in the response register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({miss_ff, access_ff, rsp_set_ff, rsp_way_ff, rsp_hit_ff});

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_no_accept_on_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !accept)
      else $error("row write overlaps an accepted item");

   a_hit_keeps_miss: assert property (@(posedge clock) disable iff (reset)
      (load_out && lk_hit) |=> (miss_ff == $past(miss_ff)))
      else $error("miss count moved on a hit");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (access_ff == $past(access_ff) + CNT_W'(1)) && rsp_tvalid)
      else $error("completed lookup not counted or not shown");
`endif

endmodule

/* test/set_assoc_cache_lru_unit_test.sv */
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_unit_test
// drives address items into the lru tag cache under several index/offset
// splits, predicts hit, way, set and both counters per item and checks every
// response in order, with random idling on both channels and one long
// response stall
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sacl_pkg::*;

   localparam int WAYS     = 4;
   localparam int SETS     = 64;
   localparam int SET_BITS = 6;
   localparam int PHASES   = 7;
   localparam int PER_PHASE = 250;

   localparam logic [CSR_AW-1:0] OFFSET_ADDR = {REG_OFFSET, 2'b00};
   localparam logic [CSR_AW-1:0] INDEX_ADDR  = {REG_INDEX, 2'b00};

   typedef struct packed {
      logic [CNT_W-1:0]     miss_total;
      logic [CNT_W-1:0]     access_total;
      logic [SET_OUT_W-1:0] set_index;
      logic [WAY_OUT_W-1:0] way_used;
      logic                 hit;
   } lookup_type;

   localparam int LOOKUP_W = $bits(lookup_type);

   class lru_tag_scoreboard;
      logic [OFF_W-1:0]  offset_bits;
      logic [IDX_W-1:0]  index_bits;
      logic [ADDR_W-1:0] tag_mem [SETS][WAYS];
      bit                valid_mem [SETS][WAYS];
      logic [1:0]        age_mem [SETS][WAYS];
      logic [CNT_W-1:0]  access_count;
      logic [CNT_W-1:0]  miss_count;
      lookup_type        lookups_due[$];
      int                failures;
      int                checked;

      function new();
         offset_bits = OFFSET_RST;
         index_bits = INDEX_RST;
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               tag_mem[s][w] = '0;
               valid_mem[s][w] = 0;
               age_mem[s][w] = 2'(w);
            end
         end
         access_count = '0;
         miss_count = '0;
         failures = 0;
         checked = 0;
      endfunction

      function void note_config(logic sel, logic [CSR_DW-1:0] value);
         if (sel == REG_OFFSET) begin
            offset_bits = value[OFF_W-1:0];
         end else begin
            index_bits = value[IDX_W-1:0];
         end
      endfunction

      function void note_access(logic [ADDR_W-1:0] address);
         int                idx_w;
         int                set_no;
         int                way;
         bit                hit;
         logic [ADDR_W-1:0] tag;
         logic [1:0]        old_age;
         lookup_type        want;
         idx_w = (index_bits > SET_BITS) ? SET_BITS : int'(index_bits);
         set_no = int'((address >> offset_bits) & ((32'd1 << idx_w) - 32'd1));
         tag = address >> (int'(offset_bits) + idx_w);
         hit = 0;
         way = 0;
         access_count++;
         for (int w = 0; w < WAYS; w++) begin
            if (!hit && valid_mem[set_no][w] && tag_mem[set_no][w] == tag) begin
               hit = 1;
               way = w;
            end
         end
         if (!hit) begin
            way = -1;
            for (int w = 0; w < WAYS; w++) begin
               if (way < 0 && !valid_mem[set_no][w]) way = w;
            end
            if (way < 0) begin
               way = 0;
               for (int w = 1; w < WAYS; w++) begin
                  if (age_mem[set_no][w] > age_mem[set_no][way]) way = w;
               end
            end
            tag_mem[set_no][way] = tag;
            valid_mem[set_no][way] = 1;
            miss_count++;
         end
         old_age = age_mem[set_no][way];
         for (int w = 0; w < WAYS; w++) begin
            if (age_mem[set_no][w] < old_age) age_mem[set_no][w]++;
         end
         age_mem[set_no][way] = 2'd0;
         want.hit = hit;
         want.way_used = WAY_OUT_W'(way);
         want.set_index = SET_OUT_W'(set_no);
         want.access_total = access_count;
         want.miss_total = miss_count;
         lookups_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] data);
         lookup_type want;
         lookup_type got;
         got = data[LOOKUP_W-1:0];
         checked++;
         if (lookups_due.size() == 0) begin
            $display("%0t unexpected response: expected none actual %h", $time, data);
            failures++;
            return;
         end
         want = lookups_due.pop_front();
         compare_field("hit", 32'(want.hit), 32'(got.hit));
         compare_field("way_used", 32'(want.way_used), 32'(got.way_used));
         compare_field("set_index", 32'(want.set_index), 32'(got.set_index));
         compare_field("access_total", want.access_total, got.access_total);
         compare_field("miss_total", want.miss_total, got.miss_total);
         compare_field("padding", 32'd0, 32'(data[RSP_W-1:LOOKUP_W]));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ADDR_W-1:0]   req_tdata;   // [31:0] address
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [0] hit, [2:1] way_used, [8:3] set_index, [40:9] access_total,
   // [72:41] miss_total, [79:73] zero
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   lru_tag_scoreboard sb;
   bit                steady;
   logic [ADDR_W-1:0] opening_addrs [17];
   int                phase_off [5];
   int                phase_idx [5];

   set_assoc_cache_lru_unit DUT (.*);

   always #4 clock = ~clock;

   task automatic send_access(logic [ADDR_W-1:0] address);
      while (!steady && $urandom_range(99) < 13) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = address;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_access(address);
      @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic [CSR_AW-1:0] addr,
                             logic [CSR_DW-1:0] wdata, output logic [CSR_DW-1:0] rdata);
      csr_psel = 1;
      csr_penable = 0;
      csr_pwrite = write;
      csr_paddr = addr;
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic apply_split(int off, int idx);
      logic [CSR_DW-1:0] rd;
      req_tvalid = 0;
      while (sb.lookups_due.size() != 0) @(negedge clock);
      csr_access(1, OFFSET_ADDR, CSR_DW'(off), rd);
      sb.note_config(REG_OFFSET, CSR_DW'(off));
      csr_access(1, INDEX_ADDR, CSR_DW'(idx), rd);
      sb.note_config(REG_INDEX, CSR_DW'(idx));
      csr_access(0, OFFSET_ADDR, '0, rd);
      sb.compare_field("offset_bits", 32'(sb.offset_bits), rd);
      csr_access(0, INDEX_ADDR, '0, rd);
      sb.compare_field("index_bits", 32'(sb.index_bits), rd);
   endtask

   // response side: random stalls plus one long hold-off while requests keep coming
   initial begin
      int hold_left;
      bit held;
      rsp_tready = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (!held && sb.checked >= 400) begin
            held = 1;
            rsp_tready = 0;
            for (hold_left = 150; hold_left > 0; hold_left--) @(negedge clock);
         end
         rsp_tready = steady || $urandom_range(99) >= 13;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int                off;
      int                idx;
      int                idx_w;
      logic [ADDR_W-1:0] tag_pool [6];
      logic [ADDR_W-1:0] set_pool [3];
      logic [ADDR_W-1:0] address;
      clock = 0;
      reset = 1;
      steady = 0;
      req_tvalid = 0;
      req_tdata = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sb = new();
      // reset split: 16-byte blocks, 64 sets
      opening_addrs = '{32'h0000_0000, 32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'h0000_0400, 32'h0000_0800, 32'h0000_0C00,
                        32'h0000_1000, 32'h0000_0400, 32'h0000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF0,
                        32'h0000_0C00};
      phase_off = '{0, 15, 8, 2, 4};
      phase_idx = '{0, 7, 6, 3, 1};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (opening_addrs[i]) send_access(opening_addrs[i]);

      for (int p = 0; p < PHASES; p++) begin
         off = (p < 5) ? phase_off[p] : $urandom_range(15);
         idx = (p < 5) ? phase_idx[p] : $urandom_range(7);
         apply_split(off, idx);
         idx_w = (idx > SET_BITS) ? SET_BITS : idx;
         // few tags over few sets so that hits and evictions both occur
         foreach (tag_pool[t]) tag_pool[t] = (t < 3) ? ADDR_W'(t) : $urandom();
         foreach (set_pool[s]) set_pool[s] = ADDR_W'($urandom_range((1 << idx_w) - 1));
         steady = (p == 2);
         repeat (PER_PHASE) begin
            if ($urandom_range(99) < 15) begin
               address = $urandom();
            end else begin
               address = (tag_pool[$urandom_range(5)] << (off + idx_w))
                       | (set_pool[$urandom_range(2)] << off)
                       | ($urandom() & ((32'd1 << off) - 32'd1));
            end
            send_access(address);
         end
         steady = 0;
      end

      req_tvalid = 0;
      while (sb.lookups_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
design/sacl_pkg.sv
design/sacl_tag_ram.sv
design/sacl_way_logic.sv
design/set_assoc_cache_lru_unit.sv
test/set_assoc_cache_lru_unit_test.sv
